>>> sv/pbrc_pkg.sv
`default_nettype none

package pbrc_pkg;

   localparam int DEPTH       = 16;
   localparam int DIM_BITS    = 12;
   localparam int SLOT_BITS   = $clog2(DEPTH);
   localparam int SKIN_BITS   = 8;
   localparam int PORT_DIM_W  = 12;
   localparam int SLOT_OUT_W  = 4;
   localparam int BUDGET_BITS = 26;
   localparam int KEY_BITS    = SKIN_BITS + 2 * DIM_BITS;
   localparam int AREA_BITS   = 2 * DIM_BITS;
   localparam int SUM_BITS    = AREA_BITS + $clog2(DEPTH + 1);
   // wide enough for the running sum and for the budget it is compared with
   localparam int TOTAL_BITS  = (SUM_BITS > BUDGET_BITS) ? SUM_BITS : BUDGET_BITS;

   localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = BUDGET_BITS'(16 * 1024 * 1024);
   localparam logic [SLOT_BITS-1:0]   LAST_SLOT    = SLOT_BITS'(DEPTH - 1);

   typedef enum logic [2:0] {
      KIND_HIT    = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_EVICT  = 3'd2,
      KIND_FLUSH  = 3'd3,
      KIND_FULL   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_CHECK,
      ST_OLD,
      ST_EVICT,
      ST_FREE,
      ST_FLUSH
   } state_type;

   // port dimension field into the key's dimension width
   function automatic logic [DIM_BITS-1:0] fit_dim(input logic [PORT_DIM_W-1:0] d);
      logic [DIM_BITS+PORT_DIM_W-1:0] t;
      t = (DIM_BITS + PORT_DIM_W)'(d);
      return t[DIM_BITS-1:0];
   endfunction

   // low bits of a slot index for the result field
   function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS+SLOT_OUT_W-1:0] t;
      t = (SLOT_BITS + SLOT_OUT_W)'(s);
      return t[SLOT_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> sv/pbrc_req_if.sv
`default_nettype none

interface pbrc_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  skin_id;
   logic [11:0] width;
   logic [11:0] height;
   logic [31:0] now_ms;

   modport source (output valid, cmd, skin_id, width, height, now_ms, input ready);
   modport sink   (input valid, cmd, skin_id, width, height, now_ms, output ready);
endinterface

`default_nettype wire

>>> sv/pbrc_rsp_if.sv
`default_nettype none

interface pbrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [3:0] slot;
   logic       last;

   modport source (output valid, kind, slot, last, input ready);
   modport sink   (input valid, kind, slot, last, output ready);
endinterface

`default_nettype wire

>>> sv/pixel_budget_render_cache.sv
`default_nettype none

// Render cache tag table: 16 slots keyed by {skin, height, width}, each with an
// insert stamp. A lookup either hits (one transaction, kind HIT) or misses; on a
// miss the cached areas plus the new area are summed, and while the sum is over
// the csr budget the valid entry with the oldest stamp strictly below now_ms is
// evicted (one EVICT transaction each, lowest slot on ties), then the lowest free
// slot is filled (INSERT) or FULL is reported with slot 0. A flush sends one
// FLUSH transaction per valid slot, none for an empty table. The final
// transaction of each request has last set. Timing: the request channel is
// ready only between requests; one area multiplier and one stamp comparator
// walk the slots one per cycle. A hit ends the match walk at the hit slot; a
// miss runs the whole match walk and a budget check, then per eviction the
// 16-slot oldest scan, the eviction and the budget check, plus one more scan
// and eviction step when the sum is still over budget and that final scan
// finds nothing older than now_ms, then the fill. A flush walks all slots.
// Any cycle that would emit a transaction stalls while the result register
// is full and not being read. Budget writes are meant for idle periods only.
module pixel_budget_render_cache
   import pbrc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   pbrc_req_if.sink                    req_chan,
   pbrc_rsp_if.source                  rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [BUDGET_BITS-1:0] csr_wr_data
);

   // sequencer state
   state_type               state_ff, state_in;
   logic [SLOT_BITS-1:0]    idx_ff, idx_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [31:0]             now_ff, now_in;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [31:0]             oldest_ff, oldest_in;
   logic [SLOT_BITS-1:0]    best_ff, best_in;
   logic [AREA_BITS-1:0]    best_area_ff, best_area_in;
   logic                    found_ff, found_in;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [BUDGET_BITS-1:0]  budget_ff;

   // tag store, written on fill only
   logic [KEY_BITS-1:0]     key_mem [DEPTH];
   logic [31:0]             stamp_mem [DEPTH];
   logic                    wr_en;
   logic [SLOT_BITS-1:0]    wr_slot;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                kind_ff;
   logic [SLOT_OUT_W-1:0]   slot_ff;
   logic                    last_ff;
   logic                    out_free;
   logic                    emit_en;
   kind_type                emit_kind;
   logic [SLOT_BITS-1:0]    emit_slot;
   logic                    emit_last;

   // shared area multiplier and slot scan taps
   logic [KEY_BITS-1:0]     mul_key;
   logic [AREA_BITS-1:0]    mul_prod;
   logic [KEY_BITS-1:0]     scan_key;
   logic [31:0]             scan_stamp;
   logic                    scan_valid;
   logic [DEPTH-1:0]        valid_above;
   logic                    free_any;
   logic [SLOT_BITS-1:0]    free_slot;
   logic                    over_budget;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign scan_key   = key_mem[idx_ff];
   assign scan_stamp = stamp_mem[idx_ff];
   assign scan_valid = valid_ff[idx_ff];

   // the accepted request's area while idle, else the scanned slot's area
   always_comb begin
      if (state_ff == ST_IDLE) begin
         mul_key = {req_chan.skin_id, fit_dim(req_chan.height), fit_dim(req_chan.width)};
      end else begin
         mul_key = scan_key;
      end
   end
   assign mul_prod = AREA_BITS'(mul_key[DIM_BITS-1:0]) *
                     AREA_BITS'(mul_key[2*DIM_BITS-1:DIM_BITS]);

   assign over_budget = total_ff > TOTAL_BITS'(budget_ff);

   // valid slots above the scan position, for last on flush
   assign valid_above = (valid_ff >> idx_ff) >> 1;

   // lowest free slot
   always_comb begin
      free_any  = 1'b0;
      free_slot = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any  = 1'b1;
            free_slot = SLOT_BITS'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      now_in       = now_ff;
      total_in     = total_ff;
      oldest_in    = oldest_ff;
      best_in      = best_ff;
      best_area_in = best_area_ff;
      found_in     = found_ff;
      valid_in     = valid_ff;
      emit_en      = 1'b0;
      emit_kind    = KIND_HIT;
      emit_slot    = idx_ff;
      emit_last    = 1'b0;
      wr_en        = 1'b0;
      wr_slot      = free_slot;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               key_in   = mul_key;
               now_in   = req_chan.now_ms;
               idx_in   = '0;
               total_in = TOTAL_BITS'(mul_prod);
               state_in = req_chan.cmd ? ST_FLUSH : ST_LOOK;
            end
         end

         // key match and area sum in one pass
         ST_LOOK: begin
            if (scan_valid && scan_key == key_ff) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_kind = KIND_HIT;
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               if (scan_valid) begin
                  total_in = total_ff + TOTAL_BITS'(mul_prod);
               end
               idx_in = idx_ff + SLOT_BITS'(1);
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            idx_in    = '0;
            oldest_in = now_ff;
            found_in  = 1'b0;
            state_in  = over_budget ? ST_OLD : ST_FREE;
         end

         // oldest stamp strictly below now; strict compare keeps the lowest slot on ties
         ST_OLD: begin
            if (scan_valid && scan_stamp < oldest_ff) begin
               oldest_in    = scan_stamp;
               best_in      = idx_ff;
               best_area_in = mul_prod;
               found_in     = 1'b1;
            end
            idx_in = idx_ff + SLOT_BITS'(1);
            if (idx_ff == LAST_SLOT) begin
               state_in = ST_EVICT;
            end
         end

         ST_EVICT: begin
            if (!found_ff) begin
               state_in = ST_FREE;
            end else if (out_free) begin
               emit_en           = 1'b1;
               emit_kind         = KIND_EVICT;
               emit_slot         = best_ff;
               valid_in[best_ff] = 1'b0;
               total_in          = total_ff - TOTAL_BITS'(best_area_ff);
               state_in          = ST_CHECK;
            end
         end

         ST_FREE: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_last = 1'b1;
               state_in  = ST_IDLE;
               if (free_any) begin
                  emit_kind           = KIND_INSERT;
                  emit_slot           = free_slot;
                  valid_in[free_slot] = 1'b1;
                  wr_en               = 1'b1;
               end else begin
                  emit_kind = KIND_FULL;
                  emit_slot = '0;
               end
            end
         end

         ST_FLUSH: begin
            if (!scan_valid || out_free) begin
               if (scan_valid) begin
                  emit_en          = 1'b1;
                  emit_kind        = KIND_FLUSH;
                  emit_last        = (valid_above == '0);
                  valid_in[idx_ff] = 1'b0;
               end
               idx_in = idx_ff + SLOT_BITS'(1);
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         budget_ff    <= BUDGET_RESET;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            budget_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      total_ff     <= total_in;
      oldest_ff    <= oldest_in;
      best_ff      <= best_in;
      best_area_ff <= best_area_in;
      found_ff     <= found_in;
      if (emit_en) begin
         kind_ff <= emit_kind;
         slot_ff <= slot_out(emit_slot);
         last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_slot]   <= key_ff;
         stamp_mem[wr_slot] <= now_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind  = kind_ff;
   assign rsp_chan.slot  = slot_ff;
   assign rsp_chan.last  = last_ff;

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;
   import pbrc_pkg::*;

   // ---------------------------------------------------------------------------
   // Run-wide constants
   // ---------------------------------------------------------------------------
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [BUDGET_BITS-1:0] BUDGET_MAX = '1;

   // An item that causes no result (flush of an empty table) keeps the block busy
   // for a full slot walk; this covers it with margin before a budget write.
   localparam int IDLE_SETTLE = 40;
   // Worst miss: the match walk, then a scan, eviction and budget check per
   // eviction; this quiet tail would expose any transaction after the last expected one.
   localparam int END_QUIET   = 340;
   // Slowest legal run: ~250 requests, each with a worst-case miss plus 17 results
   // each stuck behind an 87% idle receiver, plus sender gaps and the long stall;
   // the limit allows for that with wide margin.
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int LONG_STALL  = 300;
   localparam int BURST_ITEMS = 24;
   localparam int NUM_BURSTS  = 9;

   // ---------------------------------------------------------------------------
   // Types
   // ---------------------------------------------------------------------------
   typedef struct packed {
      kind_type              kind;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  last;
   } cache_result_type;

   // what a directed step pins down about its own final result
   typedef enum logic [1:0] {PIN_ANY, PIN_LAST, PIN_SILENT} pin_type;
   typedef enum logic {STEP_REQ, STEP_BUDGET} step_op_type;

   typedef struct packed {
      step_op_type op;
      logic        cmd;
      logic [7:0]  skin;
      logic [11:0] w;
      logic [11:0] h;
      logic [31:0] arg;     // now_ms for a request, budget value for a csr write
      logic [4:0]  rpt;     // repeat count, skin bumped by one each time
      pin_type     check;
      kind_type    kind;
      logic [3:0]  slot;
   } step_type;

   // ---------------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [BUDGET_BITS-1:0] csr_wr_data;

   pbrc_req_if req_bus ();
   pbrc_rsp_if rsp_bus ();

   initial clock = 1'b0;
   always #5 clock = ~clock;

   pixel_budget_render_cache uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // Shadow copy of the tag table, kept in step with every accepted request
   // ---------------------------------------------------------------------------
   logic                   cache_valid [DEPTH];
   logic [KEY_BITS-1:0]    cache_key   [DEPTH];
   logic [31:0]            cache_stamp [DEPTH];
   logic [BUDGET_BITS-1:0] cache_budget;

   cache_result_type new_results      [$];   // results of the request just accepted
   cache_result_type expected_results [$];   // in flight, oldest first

   // pacing and bookkeeping
   int   send_idle_pct;
   int   recv_idle_pct;
   int   rsp_hold_left;
   int   cycle_count;
   int   error_count;
   int   items_sent;
   int   results_checked;
   int   budgets_written;
   int   kind_seen [5];
   pin_type  pin_mode;
   kind_type pin_kind;
   logic [3:0] pin_slot;

   step_type plan [$];
   logic [BUDGET_BITS-1:0] burst_budget [NUM_BURSTS];
   int   burst_cap [NUM_BURSTS];

   // ---------------------------------------------------------------------------
   // Predictor helpers
   // ---------------------------------------------------------------------------
   function automatic logic [63:0] key_area(input logic [KEY_BITS-1:0] k);
      return 64'(k[DIM_BITS-1:0]) * 64'(k[2*DIM_BITS-1:DIM_BITS]);
   endfunction

   function automatic void queue_result(input kind_type k, input int sl);
      cache_result_type r;
      r.kind = k;
      r.slot = 4'(sl);
      r.last = 1'b0;
      new_results.push_back(r);
   endfunction

   // One request against the shadow table. Fills new_results with the ordered
   // transactions the block owes for it and updates the shadow state.
   task automatic predict_cache_access(input logic c, input logic [7:0] s,
                                       input logic [11:0] w, input logic [11:0] h,
                                       input logic [31:0] t);
      logic [KEY_BITS-1:0] key;
      logic [63:0]         total;
      logic [31:0]         oldest;
      int                  oldest_slot;
      int                  free_slot;
      int                  hit_slot;
      int                  i;
      logic                nothing_older;
      cache_result_type    r;
      key = {s, h, w};
      new_results.delete();
      if (c == CMD_FLUSH) begin
         // every live slot goes, lowest first; an empty table says nothing
         for (i = 0; i < DEPTH; i++) begin
            if (cache_valid[i]) begin
               queue_result(KIND_FLUSH, i);
               cache_valid[i] = 1'b0;
            end
         end
      end else begin
         hit_slot = -1;
         for (i = 0; i < DEPTH; i++)
            if (hit_slot < 0 && cache_valid[i] && cache_key[i] == key)
               hit_slot = i;
         if (hit_slot >= 0) begin
            // hits leave the stamp alone
            queue_result(KIND_HIT, hit_slot);
         end else begin
            total = 64'(w) * 64'(h);
            for (i = 0; i < DEPTH; i++)
               if (cache_valid[i])
                  total += key_area(cache_key[i]);
            // evict strictly-older entries, oldest first, lowest slot on ties,
            // until under budget or nothing older than now is left
            nothing_older = 1'b0;
            while (total > 64'(cache_budget) && !nothing_older) begin
               oldest      = t;
               oldest_slot = -1;
               for (i = 0; i < DEPTH; i++) begin
                  if (cache_valid[i] && cache_stamp[i] < oldest) begin
                     oldest      = cache_stamp[i];
                     oldest_slot = i;
                  end
               end
               if (oldest_slot < 0) begin
                  nothing_older = 1'b1;
               end else begin
                  cache_valid[oldest_slot] = 1'b0;
                  total -= key_area(cache_key[oldest_slot]);
                  queue_result(KIND_EVICT, oldest_slot);
               end
            end
            free_slot = -1;
            for (i = 0; i < DEPTH; i++)
               if (free_slot < 0 && !cache_valid[i])
                  free_slot = i;
            if (free_slot < 0) begin
               // evictions above, if any, stay done
               queue_result(KIND_FULL, 0);
            end else begin
               cache_valid[free_slot] = 1'b1;
               cache_key[free_slot]   = key;
               cache_stamp[free_slot] = t;
               queue_result(KIND_INSERT, free_slot);
            end
         end
      end
      if (new_results.size() != 0) begin
         r      = new_results.pop_back();
         r.last = 1'b1;
         new_results.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      $display("[cycle %0d] mismatch on %s: got %0d, expected %0d",
               cycle_count, what, got, want);
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, where the DUT outputs
   // and our own falling-edge drives are both settled.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      cache_result_type want;
      cache_result_type fin;
      int               i;
      if (!reset) begin
         if (csr_wr_en)
            cache_budget = csr_wr_data;

         if (req_bus.valid && req_bus.ready) begin
            predict_cache_access(req_bus.cmd, req_bus.skin_id, req_bus.width,
                                 req_bus.height, req_bus.now_ms);
            // directed steps with a hand-written outcome are held to it as well
            case (pin_mode)
               PIN_SILENT: begin
                  if (new_results.size() != 0)
                     report_mismatch("transaction count of directed step",
                                     new_results.size(), 0);
               end
               PIN_LAST: begin
                  if (new_results.size() == 0) begin
                     report_mismatch("transaction count of directed step", 0, 1);
                  end else begin
                     fin = new_results[new_results.size()-1];
                     if (fin.kind != pin_kind)
                        report_mismatch("final kind of directed step", fin.kind, pin_kind);
                     if (fin.slot != pin_slot)
                        report_mismatch("final slot of directed step", fin.slot, pin_slot);
                  end
               end
               default: ;
            endcase
            pin_mode = PIN_ANY;
            for (i = 0; i < new_results.size(); i++)
               expected_results.push_back(new_results[i]);
         end

         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("transaction with nothing expected, kind", rsp_bus.kind, -1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.kind !== want.kind)
                  report_mismatch("kind", rsp_bus.kind, want.kind);
               if (rsp_bus.slot !== want.slot)
                  report_mismatch("slot", rsp_bus.slot, want.slot);
               if (rsp_bus.last !== want.last)
                  report_mismatch("last", rsp_bus.last, want.last);
               kind_seen[int'(want.kind)]++;
               results_checked++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout at cycle %0d, %0d transactions still outstanding",
                  cycle_count, expected_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Result side: random back-pressure, plus a long stall on request that is
   // counted down here so the sender keeps pushing into a full block.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so a back-to-back request needs only one drive.
   task automatic send_request(input logic c, input logic [7:0] s, input logic [11:0] w,
                               input logic [11:0] h, input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.cmd     <= c;
      req_bus.skin_id <= s;
      req_bus.width   <= w;
      req_bus.height  <= h;
      req_bus.now_ms  <= t;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Sender stops and waits until every owed transaction has been seen, then
   // lets a silent request (empty flush) finish its slot walk.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic set_budget(input logic [BUDGET_BITS-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      budgets_written++;
   endtask

   function automatic step_type req_step(input logic c, input int s, input int w,
                                         input int h, input logic [31:0] t,
                                         input int rpt, input pin_type chk,
                                         input kind_type kd, input int sl);
      step_type st;
      st.op    = STEP_REQ;
      st.cmd   = c;
      st.skin  = 8'(s);
      st.w     = 12'(w);
      st.h     = 12'(h);
      st.arg   = t;
      st.rpt   = 5'(rpt);
      st.check = chk;
      st.kind  = kd;
      st.slot  = 4'(sl);
      return st;
   endfunction

   function automatic step_type budget_step(input logic [BUDGET_BITS-1:0] value);
      step_type st;
      st       = req_step(CMD_LOOKUP, 0, 0, 0, 32'(value), 1, PIN_ANY, KIND_HIT, 0);
      st.op    = STEP_BUDGET;
      return st;
   endfunction

   // A burst of random requests. Most of them draw from a small pool of keys so
   // that hits and re-inserts happen; the rest are fresh keys. Time mostly runs
   // forward, sometimes stands still (ties, nothing older), sometimes steps back
   // or jumps anywhere in the 32-bit range.
   task automatic run_burst(input int n, input int cap, input int hold,
                            inout logic [31:0] clock_ms);
      logic [7:0]  pool_skin [8];
      logic [11:0] pool_w    [8];
      logic [11:0] pool_h    [8];
      logic        c;
      logic [7:0]  s;
      logic [11:0] w;
      logic [11:0] h;
      int          j;
      int          k;
      int          roll;
      for (j = 0; j < 8; j++) begin
         pool_skin[j] = 8'($urandom);
         pool_w[j]    = 12'($urandom_range(0, cap));
         pool_h[j]    = 12'($urandom_range(0, cap));
      end
      for (k = 0; k < n; k++) begin
         // long receiver stall while the sender keeps offering requests
         if (hold != 0 && k == 4)
            rsp_hold_left = hold;
         roll = $urandom_range(99);
         c    = (roll < 5) ? CMD_FLUSH : CMD_LOOKUP;
         if (roll < 62) begin
            j = $urandom_range(7);
            s = pool_skin[j];
            w = pool_w[j];
            h = pool_h[j];
         end else begin
            s = 8'($urandom);
            w = 12'($urandom_range(0, cap));
            h = 12'($urandom_range(0, cap));
            if ($urandom_range(9) == 0) w = 12'($urandom);
            if ($urandom_range(9) == 0) h = 12'($urandom);
         end
         roll = $urandom_range(99);
         if (roll < 70)
            clock_ms = clock_ms + 32'($urandom_range(1, 40));
         else if (roll < 92)
            clock_ms = clock_ms - 32'($urandom_range(0, 100));
         else if (roll >= 97)
            clock_ms = $urandom;
         send_request(c, s, w, h, clock_ms);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      step_type    st;
      int          i;
      int          k;
      int          m;
      int          directed_items;
      logic [31:0] clock_ms;

      // every DUT input known from time zero
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.cmd     = CMD_LOOKUP;
      req_bus.skin_id = '0;
      req_bus.width   = '0;
      req_bus.height  = '0;
      req_bus.now_ms  = '0;
      rsp_bus.ready   = 1'b0;

      cache_budget = BUDGET_RESET;
      for (i = 0; i < DEPTH; i++) begin
         cache_valid[i] = 1'b0;
         cache_key[i]   = '0;
         cache_stamp[i] = '0;
      end
      for (i = 0; i < 5; i++)
         kind_seen[i] = 0;
      rsp_hold_left   = 0;
      cycle_count     = 0;
      error_count     = 0;
      items_sent      = 0;
      results_checked = 0;
      budgets_written = 0;
      pin_mode        = PIN_ANY;
      pin_kind        = KIND_HIT;
      pin_slot        = '0;
      send_idle_pct   = 31;
      recv_idle_pct   = 87;

      // Directed steps. Outcomes are written in only where they are obvious;
      // the rest are left to the predictor.
      // flush of an empty table owes nothing
      plan.push_back(req_step(CMD_FLUSH, 0, 0, 0, 0, 1, PIN_SILENT, KIND_HIT, 0));
      // zero-area key, then a hit on it
      plan.push_back(req_step(CMD_LOOKUP, 0, 0, 0, 0, 1, PIN_LAST, KIND_INSERT, 0));
      plan.push_back(req_step(CMD_LOOKUP, 0, 0, 0, 5, 1, PIN_LAST, KIND_HIT, 0));
      // largest key fits the reset budget on its own; hit at the top of time
      plan.push_back(req_step(CMD_LOOKUP, 255, 4095, 4095, 10, 1,
                              PIN_LAST, KIND_INSERT, 1));
      plan.push_back(req_step(CMD_LOOKUP, 255, 4095, 4095, 32'hFFFF_FFFF, 1,
                              PIN_LAST, KIND_HIT, 1));
      plan.push_back(req_step(CMD_LOOKUP, 1, 4095, 1, 20, 1, PIN_LAST, KIND_INSERT, 2));
      // over budget: older entries go, oldest first
      plan.push_back(req_step(CMD_LOOKUP, 2, 4095, 2, 20, 1, PIN_ANY, KIND_HIT, 0));
      // over budget but nothing strictly older than now
      plan.push_back(req_step(CMD_LOOKUP, 3, 4095, 4095, 20, 1, PIN_ANY, KIND_HIT, 0));
      // time stepped back to zero: still nothing older
      plan.push_back(req_step(CMD_LOOKUP, 4, 4095, 4095, 0, 1, PIN_ANY, KIND_HIT, 0));
      plan.push_back(req_step(CMD_FLUSH, 0, 0, 0, 30, 1, PIN_ANY, KIND_HIT, 0));
      // widest budget: fill every slot with one stamp, then hit the full table
      plan.push_back(budget_step(BUDGET_MAX));
      plan.push_back(req_step(CMD_LOOKUP, 10, 4095, 4095, 100, 1,
                              PIN_LAST, KIND_INSERT, 0));
      plan.push_back(req_step(CMD_LOOKUP, 11, 4095, 4095, 100, 1,
                              PIN_LAST, KIND_INSERT, 1));
      plan.push_back(req_step(CMD_LOOKUP, 12, 4095, 4095, 100, 1,
                              PIN_LAST, KIND_INSERT, 2));
      plan.push_back(req_step(CMD_LOOKUP, 13, 7, 3, 100, 13, PIN_ANY, KIND_HIT, 0));
      plan.push_back(req_step(CMD_LOOKUP, 40, 16, 16, 100, 1, PIN_LAST, KIND_FULL, 0));
      // zero budget: all sixteen tie on the stamp, so they leave in slot order,
      // then the new key takes slot 0 (the longest answer the block can give)
      plan.push_back(budget_step('0));
      plan.push_back(req_step(CMD_LOOKUP, 41, 2, 2, 200, 1, PIN_LAST, KIND_INSERT, 0));
      // zero-area newcomer still pushes the older entry out under a zero budget
      plan.push_back(req_step(CMD_LOOKUP, 42, 0, 9, 300, 1, PIN_LAST, KIND_INSERT, 0));
      plan.push_back(budget_step(BUDGET_RESET));
      plan.push_back(req_step(CMD_FLUSH, 0, 0, 0, 310, 1, PIN_LAST, KIND_FLUSH, 0));
      plan.push_back(req_step(CMD_LOOKUP, 43, 4095, 0, 32'hFFFF_FFFF, 1,
                              PIN_LAST, KIND_INSERT, 0));

      // budget and key-size mix per random burst; burst 4 gets a random budget
      burst_budget = '{BUDGET_RESET, '0, BUDGET_MAX, 26'd20000, '0,
                       BUDGET_MAX, BUDGET_RESET, 26'd3000000, 26'd1000};
      burst_cap    = '{4095, 255, 63, 255, 4095, 15, 4095, 2047, 31};
      burst_budget[4] = BUDGET_BITS'($urandom);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < plan.size(); i++) begin
         st = plan[i];
         if (st.op == STEP_BUDGET) begin
            set_budget(st.arg[BUDGET_BITS-1:0]);
         end else begin
            for (k = 0; k < st.rpt; k++) begin
               pin_mode = st.check;
               pin_kind = st.kind;
               pin_slot = st.slot;
               send_request(st.cmd, st.skin + 8'(k), st.w, st.h, st.arg);
            end
         end
      end
      directed_items = items_sent;

      // Random part in three pacing modes: slow sender / slow receiver, the
      // reverse, then both at full rate. Every budget change waits for the
      // block to drain first.
      clock_ms = $urandom;
      for (m = 0; m < 3; m++) begin
         case (m)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (k = 0; k < 3; k++) begin
            set_budget(burst_budget[m*3+k]);
            run_burst(BURST_ITEMS, burst_cap[m*3+k],
                      (m == 2 && k == 0) ? LONG_STALL : 0, clock_ms);
         end
      end

      wait_idle();
      repeat (END_QUIET) @(negedge clock);

      $display("Sent %0d requests (%0d directed, rest random over %0d budget settings",
               items_sent, directed_items, budgets_written);
      $display("  and three pacing modes); checked %0d transactions:", results_checked);
      $display("  %0d hit, %0d insert, %0d evict, %0d flush, %0d full",
               kind_seen[KIND_HIT], kind_seen[KIND_INSERT],
               kind_seen[KIND_EVICT], kind_seen[KIND_FLUSH], kind_seen[KIND_FULL]);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
